>>> rtl/core/slec_pkg.sv
// shared types and constants for the stack-language execute core
package slec_pkg;

  typedef struct packed {
    logic        mode;
    logic [7:0]  instr_char;
    logic signed [31:0] supplied_value;
    logic [1:0]  random_dir;
  } slec_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic signed [31:0] out_value;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic [1:0]  direction;
    logic [1:0]  step_length;
    logic        divide_by_zero;
    logic        stack_overflow;
  } slec_out_t;

  // host request codes
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_PRINT_INT = 3'd1;
  localparam logic [2:0] ACT_PRINT_CHR = 3'd2;
  localparam logic [2:0] ACT_PUT       = 3'd3;
  localparam logic [2:0] ACT_GET       = 3'd4;
  localparam logic [2:0] ACT_READ_INT  = 3'd5;
  localparam logic [2:0] ACT_READ_CHR  = 3'd6;
  localparam logic [2:0] ACT_HALT      = 3'd7;

  // directions
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // string states
  localparam logic [1:0] STR_OFF = 2'd0;
  localparam logic [1:0] STR_ON  = 2'd1;
  localparam logic [1:0] STR_ESC = 2'd2;

  // instruction bytes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_NOT   = 8'h21;
  localparam logic [7:0] CH_GT    = 8'h60;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_UP    = 8'h5E;
  localparam logic [7:0] CH_DOWN  = 8'h76;
  localparam logic [7:0] CH_RAND  = 8'h3F;
  localparam logic [7:0] CH_HIF   = 8'h5F;
  localparam logic [7:0] CH_VIF   = 8'h7C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DUP   = 8'h3A;
  localparam logic [7:0] CH_SWAP  = 8'h5C;
  localparam logic [7:0] CH_DROP  = 8'h24;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_TRAMP = 8'h23;
  localparam logic [7:0] CH_PUT   = 8'h70;
  localparam logic [7:0] CH_GETC  = 8'h67;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_AT    = 8'h40;

endpackage

>>> rtl/core/stack_language_execute_core.sv
// top level of the stack-language execute core: sequencer, stack memory, shared alu
//
//  channel | ports                        | direction | payload
//  input   | in_valid, in_ready, in_data  | in        | slec_in_t
//  result  | out_valid, out_ready, out_data | out     | slec_out_t
//
// one item at a time: in_ready is high only in idle. an item with no pops
// runs through execute, push and done before its result is shown; each pop
// adds an address state and a state for the registered read data, or the
// address state alone on an empty stack, and swap adds a second push. multiply
// steps through the multiplier 8 bits at a time, and divide and remainder
// use the one-bit-per-cycle restoring divider in the shared unit. a result
// waits in the output register while out_ready is low; no new item is taken
// until it leaves. reset clears count, direction, string state and halt at once.
module stack_language_execute_core #(
  parameter int STACK_DEPTH = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  slec_pkg::slec_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output slec_pkg::slec_out_t  out_data
);
  import slec_pkg::*;

  localparam int VW  = VALUE_WIDTH;
  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int KW  = $clog2(VW + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  // multiply consumes 8 multiplier bits a step
  localparam int MSTEPS = (VW + 7) / 8;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POPRQ = 4'd1;
  localparam logic [3:0] S_POPWT = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DIVF  = 4'd6;
  localparam logic [3:0] S_PUSH1 = 4'd7;
  localparam logic [3:0] S_PUSH2 = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [1:0]    str_r, str_nxt;
  logic          halted_r, halted_nxt;
  slec_in_t      item_r;
  slec_out_t     res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;

  // popped operands: opa first popped, opb second, opc third
  logic [VW-1:0] opa_r, opa_nxt, opb_r, opb_nxt, opc_r, opc_nxt;
  logic [1:0]    npop_r, npop_nxt, popi_r, popi_nxt;
  logic [VW-1:0] pa_r, pa_nxt, pb_r, pb_nxt;   // values to push
  logic [1:0]    npush_r, npush_nxt;
  logic          ovf_r, ovf_nxt;

  // shared unit registers
  logic [VW-1:0] acc_r, acc_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [KW-1:0] k_r, k_nxt;

  // stack memory
  logic [VW-1:0] mem [STACK_DEPTH];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  function automatic logic [31:0] to32(input logic [VW-1:0] v);
    logic [63:0] e;
    e = 64'(signed'(v));
    return e[31:0];
  endfunction

  logic [7:0]    ch;
  logic          is_digit;
  logic [VW-1:0] sub_res, ma, mb;
  logic [VW:0]   trial;
  logic [VW+7:0] mpart;

  assign ch = item_r.instr_char;
  assign is_digit = (ch >= CH_0) && (ch <= CH_9);
  assign raddr = AW'(cnt_r - CW'(1));
  // magnitudes for the divider
  assign ma = opa_r[VW-1] ? (VW'(0) - opa_r) : opa_r;
  assign mb = opb_r[VW-1] ? (VW'(0) - opb_r) : opb_r;
  assign trial = {acc_r, quo_r[VW-1]} - {1'b0, den_r};
  assign mpart = {8'd0, acc_r} + (VW+8)'(opb_r * opa_r[7:0]);

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; dir_nxt = dir_r; str_nxt = str_r;
    halted_nxt = halted_r; res_nxt = res_r; out_valid_nxt = out_valid_r;
    opa_nxt = opa_r; opb_nxt = opb_r; opc_nxt = opc_r;
    npop_nxt = npop_r; popi_nxt = popi_r; pa_nxt = pa_r; pb_nxt = pb_r;
    npush_nxt = npush_r; ovf_nxt = ovf_r;
    acc_nxt = acc_r; quo_nxt = quo_r; den_nxt = den_r; k_nxt = k_r;
    we = 1'b0; waddr = AW'(cnt_r); wdata = pa_r;
    sub_res = opb_r - opa_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          res_nxt.step_length = 2'd1;
          opa_nxt = '0; opb_nxt = '0; opc_nxt = '0;
          npush_nxt = 2'd0; popi_nxt = 2'd0; ovf_nxt = 1'b0;
          npop_nxt = 2'd0;
          state_nxt = S_EXEC;
          if (!halted_r && in_data.mode == 1'b0 && str_r == STR_OFF) begin
            case (in_data.instr_char)
              CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD, CH_GT, CH_SWAP, CH_GETC:
                npop_nxt = 2'd2;
              CH_NOT, CH_HIF, CH_VIF, CH_DROP, CH_DOT, CH_COMMA:
                npop_nxt = 2'd1;
              CH_PUT: npop_nxt = 2'd3;
              CH_DUP: npop_nxt = 2'd1;
              default: npop_nxt = 2'd0;
            endcase
            if (npop_nxt != 2'd0) begin
              state_nxt = S_POPRQ;
            end
          end
        end
      end
      // raddr presents top of stack; data arrives next cycle
      S_POPRQ: begin
        if (cnt_r == '0) begin
          popi_nxt = popi_r + 2'd1;
          if (popi_r + 2'd1 == npop_r) begin
            state_nxt = S_EXEC;
          end
        end else begin
          state_nxt = S_POPWT;
        end
      end
      S_POPWT: begin
        case (popi_r)
          2'd0: opa_nxt = rdata_r;
          2'd1: opb_nxt = rdata_r;
          default: opc_nxt = rdata_r;
        endcase
        // duplicate peeks without removing
        if (ch != CH_DUP) begin
          cnt_nxt = cnt_r - CW'(1);
        end
        popi_nxt = popi_r + 2'd1;
        state_nxt = (popi_r + 2'd1 == npop_r) ? S_EXEC : S_POPRQ;
      end
      S_EXEC: begin
        state_nxt = S_PUSH1;
        if (halted_r) begin
          res_nxt.action = ACT_HALT;
        end else if (item_r.mode) begin
          pa_nxt = VW'(item_r.supplied_value); npush_nxt = 2'd1;
        end else if (str_r != STR_OFF) begin
          if (str_r == STR_ON && ch == CH_QUOTE) begin
            str_nxt = STR_OFF;
          end else if (str_r == STR_ON && ch == CH_SWAP) begin
            str_nxt = STR_ESC;
          end else begin
            pa_nxt = VW'(ch); npush_nxt = 2'd1; str_nxt = STR_ON;
          end
        end else if (is_digit) begin
          pa_nxt = VW'(ch - CH_0); npush_nxt = 2'd1;
        end else begin
          case (ch)
            CH_ADD: begin pa_nxt = opb_r + opa_r; npush_nxt = 2'd1; end
            CH_SUB: begin pa_nxt = sub_res; npush_nxt = 2'd1; end
            CH_MUL: begin
              acc_nxt = '0; k_nxt = '0; state_nxt = S_MUL;
            end
            CH_DIV, CH_MOD: begin
              npush_nxt = 2'd1;
              if (opa_r == '0) begin
                pa_nxt = '0; res_nxt.divide_by_zero = 1'b1;
              end else begin
                acc_nxt = '0; quo_nxt = mb; den_nxt = ma; k_nxt = '0;
                state_nxt = S_DIV;
              end
            end
            CH_NOT: begin pa_nxt = VW'(opa_r == '0); npush_nxt = 2'd1; end
            CH_GT: begin
              pa_nxt = VW'($signed(opb_r) > $signed(opa_r)); npush_nxt = 2'd1;
            end
            CH_RIGHT: dir_nxt = DIR_RIGHT;
            CH_LEFT:  dir_nxt = DIR_LEFT;
            CH_UP:    dir_nxt = DIR_UP;
            CH_DOWN:  dir_nxt = DIR_DOWN;
            CH_RAND:  dir_nxt = item_r.random_dir;
            CH_HIF:   dir_nxt = (opa_r == '0) ? DIR_RIGHT : DIR_LEFT;
            CH_VIF:   dir_nxt = (opa_r == '0) ? DIR_DOWN : DIR_UP;
            CH_QUOTE: str_nxt = STR_ON;
            CH_DUP:   begin pa_nxt = opa_r; npush_nxt = 2'd1; end
            CH_SWAP:  begin pa_nxt = opa_r; pb_nxt = opb_r; npush_nxt = 2'd2; end
            CH_DOT:   begin res_nxt.action = ACT_PRINT_INT; res_nxt.out_value = to32(opa_r); end
            CH_COMMA: begin res_nxt.action = ACT_PRINT_CHR; res_nxt.out_value = to32(opa_r); end
            CH_TRAMP: res_nxt.step_length = 2'd2;
            CH_PUT: begin
              res_nxt.action = ACT_PUT; res_nxt.out_value = to32(opc_r);
              res_nxt.cell_x = to32(opb_r); res_nxt.cell_y = to32(opa_r);
            end
            CH_GETC: begin
              res_nxt.action = ACT_GET;
              res_nxt.cell_x = to32(opb_r); res_nxt.cell_y = to32(opa_r);
            end
            CH_AMP:   res_nxt.action = ACT_READ_INT;
            CH_TILDE: res_nxt.action = ACT_READ_CHR;
            CH_AT: begin res_nxt.action = ACT_HALT; halted_nxt = 1'b1; end
            default: ;
          endcase
        end
      end
      // shift-add multiply, 8 bits of opa a step
      S_MUL: begin
        acc_nxt = mpart[VW-1:0];
        opb_nxt = opb_r << 8;
        opa_nxt = opa_r >> 8;
        k_nxt = k_r + KW'(1);
        if (k_r == KW'(MSTEPS - 1)) begin
          pa_nxt = mpart[VW-1:0]; npush_nxt = 2'd1; state_nxt = S_PUSH1;
        end
      end
      // restoring divide, one quotient bit a cycle
      S_DIV: begin
        quo_nxt = {quo_r[VW-2:0], ~trial[VW]};
        acc_nxt = trial[VW] ? {acc_r[VW-2:0], quo_r[VW-1]} : trial[VW-1:0];
        k_nxt = k_r + KW'(1);
        if (k_r == KW'(VW - 1)) begin
          state_nxt = S_DIVF;
        end
      end
      S_DIVF: begin
        if (ch == CH_DIV) begin
          pa_nxt = (opa_r[VW-1] ^ opb_r[VW-1]) ? (VW'(0) - quo_r) : quo_r;
        end else begin
          pa_nxt = opb_r[VW-1] ? (VW'(0) - acc_r) : acc_r;
        end
        state_nxt = S_PUSH1;
      end
      S_PUSH1: begin
        if (npush_r != 2'd0) begin
          if (cnt_r >= DEPTH_C) begin
            ovf_nxt = 1'b1;
          end else begin
            we = 1'b1; cnt_nxt = cnt_r + CW'(1);
          end
        end
        pa_nxt = pb_r;
        npush_nxt = (npush_r == 2'd2) ? 2'd1 : 2'd0;
        state_nxt = (npush_r == 2'd2) ? S_PUSH1 : S_DONE;
      end
      S_DONE: begin
        res_nxt.direction = dir_r;
        res_nxt.stack_overflow = ovf_r;
        out_valid_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; dir_r <= DIR_RIGHT; str_r <= STR_OFF;
      halted_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; dir_r <= dir_nxt; str_r <= str_nxt;
      halted_r <= halted_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
    res_r <= res_nxt;
    opa_r <= opa_nxt; opb_r <= opb_nxt; opc_r <= opc_nxt;
    npop_r <= npop_nxt; popi_r <= popi_nxt; pa_r <= pa_nxt; pb_r <= pb_nxt;
    npush_r <= npush_nxt; ovf_r <= ovf_nxt;
    acc_r <= acc_nxt; quo_r <= quo_nxt; den_r <= den_nxt; k_r <= k_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule
